@@ rtl/core/stq_pkg.sv @@
// Shared types, command codes and helper functions for the sorted timer queue.
// Used by stq_front, stq_engine and sorted_timer_queue; depends on nothing.
`default_nettype none

package stq_pkg;

	// Command codes as they arrive on the input stream.
	localparam logic [1:0] CMD_TICK   = 2'd0;
	localparam logic [1:0] CMD_ARM    = 2'd1;
	localparam logic [1:0] CMD_CANCEL = 2'd2;
	localparam logic [1:0] CMD_FLUSH  = 2'd3;

	localparam int         SLOT_W      = 4;
	localparam int         TIME_W      = 32;
	localparam int         LEAD_W      = 10;
	localparam logic [LEAD_W-1:0] LEAD_RESET = 10'd10;
	localparam int         MAX_RESULTS = 16;
	localparam int         RES_CW      = $clog2(MAX_RESULTS + 1);
	localparam int         RES_IW      = $clog2(MAX_RESULTS);

	// Decoded operation handed from the front end to the engine.
	typedef enum logic [2:0] {
		OP_TICK,
		OP_ARM,
		OP_CANCEL,
		OP_FLUSH,
		OP_NOP
	} stq_op_t;

	typedef struct packed {
		stq_op_t             op;
		logic [SLOT_W-1:0]   slot;
		logic [TIME_W-1:0]   expire;
	} stq_cmd_t;

	// One result beat before packing onto the output stream.
	typedef struct packed {
		logic                fired;
		logic [SLOT_W-1:0]   fired_slot;
		logic                last;
		logic [TIME_W-1:0]   now_count;
		logic [TIME_W-1:0]   expire_used;
		logic                compare_armed;
		logic [TIME_W-1:0]   compare_at;
	} stq_res_t;

	// Wrap-aware "a strictly later than b".
	function automatic logic is_after(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
		logic [TIME_W-1:0] d;
		d = a - b;
		return (d != '0) && !d[TIME_W-1];
	endfunction

	// Wrap-aware "a at or later than b".
	function automatic logic is_after_eq(input logic [TIME_W-1:0] a,
			input logic [TIME_W-1:0] b);
		logic [TIME_W-1:0] d;
		d = a - b;
		return !d[TIME_W-1];
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/stq_front.sv @@
// Front end: accepts input beats, decodes and range-checks them, and holds
// them in a two-entry command queue for the engine. Depends on stq_pkg.
`default_nettype none

module stq_front import stq_pkg::*; #(
	parameter int SLOT_COUNT = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        in_command,
	input  wire logic [SLOT_W-1:0] in_slot,
	input  wire logic [TIME_W-1:0] in_expire,
	output logic                   cmd_valid,
	input  wire logic              cmd_ready,
	output stq_cmd_t               cmd
);

	stq_cmd_t   fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	stq_cmd_t   decoded;
	logic       push;
	logic       pop;
	logic       in_range;

	// Classify the incoming beat; an arm or cancel naming a slot beyond the table becomes a no-op.
	always_comb begin
		in_range       = 32'(in_slot) < SLOT_COUNT;
		decoded.slot   = in_slot;
		decoded.expire = in_expire;
		case (in_command)
			CMD_TICK:   decoded.op = OP_TICK;
			CMD_ARM:    decoded.op = in_range ? OP_ARM : OP_NOP;
			CMD_CANCEL: decoded.op = in_range ? OP_CANCEL : OP_NOP;
			CMD_FLUSH:  decoded.op = OP_FLUSH;
			default:    decoded.op = OP_NOP;
		endcase
	end

	assign in_ready  = count_q != 2'd2;
	assign cmd_valid = count_q != 2'd0;
	assign cmd       = fifo_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= decoded;
		end
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/stq_engine.sv @@
// Back end: tick counter, compare register, the sorted slot queue and the
// result register. Takes decoded commands from stq_front; depends on stq_pkg.
`default_nettype none

module stq_engine import stq_pkg::*; #(
	parameter int SLOT_COUNT = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [LEAD_W-1:0] cfg_wdata,
	input  wire logic              cmd_valid,
	output logic                   cmd_ready,
	input  wire stq_cmd_t          cmd,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output stq_res_t               res
);

	localparam int LEN_W = $clog2(SLOT_COUNT + 1);
	localparam int POS_W = $clog2(SLOT_COUNT);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLAMP,
		ST_UNLINK,
		ST_LINK,
		ST_HEAD,
		ST_POP,
		ST_PROG,
		ST_EMIT
	} state_t;

	state_t                 state_q;
	logic [LEAD_W-1:0]      min_lead_q;
	logic [TIME_W-1:0]      tick_q;
	logic [TIME_W-1:0]      cmp_q;
	logic                   cmp_on_q;
	logic [LEN_W-1:0]       len_q;
	logic [SLOT_W-1:0]      q_slot_q [SLOT_COUNT];
	logic [TIME_W-1:0]      q_exp_q  [SLOT_COUNT];
	stq_op_t                op_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [TIME_W-1:0]      req_q;
	logic [TIME_W-1:0]      used_q;
	logic [TIME_W-1:0]      target_q;
	logic [SLOT_W-1:0]      pop_buf_q [MAX_RESULTS];
	logic [RES_CW-1:0]      npop_q;
	logic [RES_CW-1:0]      idx_q;
	logic                   out_valid_q;
	stq_res_t               out_q;

	logic [LEAD_W-1:0]      lead;
	logic [TIME_W-1:0]      floor_now;
	logic [TIME_W-1:0]      tick_next;
	logic                   unl_hit;
	logic [POS_W-1:0]       unl_pos;
	logic [POS_W-1:0]       lnk_pos;
	logic                   out_free;
	logic                   emit_last;

	assign lead      = (min_lead_q == '0) ? LEAD_W'(1) : min_lead_q;
	assign floor_now = tick_q + TIME_W'(lead);
	assign tick_next = tick_q + TIME_W'(1);
	assign out_free  = !out_valid_q || res_ready;
	assign emit_last = (npop_q == '0) || (idx_q == npop_q - RES_CW'(1));
	assign cmd_ready = state_q == ST_IDLE;
	assign res_valid = out_valid_q;
	assign res       = out_q;

	// Locate the slot to remove: lowest queued position holding slot_q.
	always_comb begin
		unl_hit = 1'b0;
		unl_pos = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (i < int'(len_q) && q_slot_q[i] == slot_q) begin
				unl_hit = 1'b1;
				unl_pos = POS_W'(i);
			end
		end
	end

	// Insert point: first entry strictly later than the new expiry, else the tail.
	always_comb begin
		lnk_pos = POS_W'(len_q);
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (i < int'(len_q) && is_after(q_exp_q[i], req_q)) begin
				lnk_pos = POS_W'(i);
			end
		end
	end

	// Minimum lead register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_lead_q <= LEAD_RESET;
		end else if (cfg_we) begin
			min_lead_q <= cfg_wdata;
		end
	end

	// Queue entries and popped-slot buffer hold no reset value.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_UNLINK: begin
				if (unl_hit) begin
					for (int i = 0; i < SLOT_COUNT - 1; i++) begin
						if (i >= int'(unl_pos)) begin
							q_slot_q[i] <= q_slot_q[i+1];
							q_exp_q[i]  <= q_exp_q[i+1];
						end
					end
				end
			end
			ST_LINK: begin
				for (int i = 0; i < SLOT_COUNT; i++) begin
					if (i == int'(lnk_pos)) begin
						q_slot_q[i] <= slot_q;
						q_exp_q[i]  <= req_q;
					end else if (i > int'(lnk_pos)) begin
						q_slot_q[i] <= q_slot_q[i-1];
						q_exp_q[i]  <= q_exp_q[i-1];
					end
				end
			end
			ST_POP: begin
				if (len_q != '0 && npop_q != RES_CW'(MAX_RESULTS)
						&& is_after_eq(tick_q, q_exp_q[0])) begin
					pop_buf_q[npop_q[RES_IW-1:0]] <= q_slot_q[0];
					for (int i = 0; i < SLOT_COUNT - 1; i++) begin
						q_slot_q[i] <= q_slot_q[i+1];
						q_exp_q[i]  <= q_exp_q[i+1];
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Command sequencer, timer registers and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tick_q      <= '0;
			cmp_q       <= '0;
			cmp_on_q    <= 1'b0;
			len_q       <= '0;
			op_q        <= OP_NOP;
			slot_q      <= '0;
			req_q       <= '0;
			used_q      <= '0;
			target_q    <= '0;
			npop_q      <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (res_ready && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						op_q   <= cmd.op;
						slot_q <= cmd.slot;
						req_q  <= cmd.expire;
						used_q <= '0;
						npop_q <= '0;
						idx_q  <= '0;
						case (cmd.op)
							OP_TICK: begin
								tick_q <= tick_next;
								if (cmp_on_q && tick_next == cmp_q) begin
									cmp_on_q <= 1'b0;
									state_q  <= ST_POP;
								end else begin
									state_q  <= ST_EMIT;
								end
							end
							OP_ARM:    state_q <= ST_CLAMP;
							OP_CANCEL: state_q <= ST_UNLINK;
							OP_FLUSH: begin
								len_q    <= '0;
								cmp_on_q <= 1'b0;
								tick_q   <= '0;
								state_q  <= ST_EMIT;
							end
							default:   state_q <= ST_EMIT;
						endcase
					end
				end
				// Hold the expiry off to at least now plus the lead.
				ST_CLAMP: begin
					if (is_after_eq(floor_now, req_q)) begin
						req_q  <= floor_now;
						used_q <= floor_now;
					end else begin
						used_q <= req_q;
					end
					state_q <= ST_UNLINK;
				end
				ST_UNLINK: begin
					if (unl_hit) begin
						len_q <= len_q - LEN_W'(1);
					end
					state_q <= (op_q == OP_ARM) ? ST_LINK : ST_EMIT;
				end
				ST_LINK: begin
					len_q   <= len_q + LEN_W'(1);
					state_q <= ST_HEAD;
				end
				// A head whose expiry equals this one reprograms the compare.
				ST_HEAD: begin
					target_q <= req_q;
					state_q  <= (q_exp_q[0] == req_q) ? ST_PROG : ST_EMIT;
				end
				// Pop due entries from the head, one per cycle; a head not yet due reprograms the compare.
				ST_POP: begin
					if (len_q == '0 || npop_q == RES_CW'(MAX_RESULTS)) begin
						state_q <= ST_EMIT;
					end else if (is_after_eq(tick_q, q_exp_q[0])) begin
						len_q  <= len_q - LEN_W'(1);
						npop_q <= npop_q + RES_CW'(1);
					end else begin
						target_q <= q_exp_q[0] + TIME_W'(lead);
						state_q  <= ST_PROG;
					end
				end
				ST_PROG: begin
					cmp_q    <= is_after(target_q, tick_q) ? target_q : floor_now;
					cmp_on_q <= 1'b1;
					state_q  <= ST_EMIT;
				end
				// One result beat per popped slot, or a single plain beat.
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q         <= 1'b1;
						out_q.fired         <= npop_q != '0;
						out_q.fired_slot    <= (npop_q != '0) ? pop_buf_q[idx_q[RES_IW-1:0]] : '0;
						out_q.last          <= emit_last;
						out_q.now_count     <= tick_q;
						out_q.expire_used   <= used_q;
						out_q.compare_armed <= cmp_on_q;
						out_q.compare_at    <= cmp_q;
						idx_q               <= idx_q + RES_CW'(1);
						if (emit_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/sorted_timer_queue.sv @@
// Sorted timer queue: a 32-bit tick counter with a compare register in front of
// an expiry-ordered queue of timer slots. Commands arrive one beat at a time
// and land in a two-entry command queue, so the input accepts up to two commands
// while the engine works and while a result beat waits on the output. The
// engine handles one command at a time: a tick without a compare match, a flush
// or an out-of-range slot goes straight to its result; a cancel removes the
// slot, whether or not it is queued, then gives its result; an arm steps through
// clamp, remove, sorted insert, head check, compare update (only when the head
// carries the new expiry) and result. A tick that matches the compare pops one
// due slot per cycle, reprograms the compare when it meets an entry not yet due,
// and then sends one result beat per popped slot. Result beats wait while the
// output stalls. Sorted insert and remove each act on all slot entries in one
// state. min_lead may be written only while no command is in flight.
// Depends on stq_pkg, stq_front and stq_engine.
`default_nettype none

module sorted_timer_queue import stq_pkg::*; #(
	parameter int SLOT_COUNT = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [LEAD_W-1:0]  cfg_wdata,
	input  wire logic               s_axis_tvalid,
	output logic                    s_axis_tready,
	// [3:0] slot_id, [35:4] expire_at, [39:36] zero
	input  wire logic [39:0]        s_axis_tdata,
	// [1:0] command
	input  wire logic [1:0]         s_axis_tuser,
	output logic                    m_axis_tvalid,
	input  wire logic               m_axis_tready,
	// [3:0] fired_slot, [35:4] now_count, [67:36] expire_used,
	// [68] compare_armed, [100:69] compare_at, [103:101] zero
	output logic [103:0]            m_axis_tdata,
	// [0] fired
	output logic                    m_axis_tuser,
	output logic                    m_axis_tlast
);

	logic     cmd_valid;
	logic     cmd_ready;
	stq_cmd_t cmd;
	stq_res_t res;

	stq_front #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_command(s_axis_tuser),
		.in_slot   (s_axis_tdata[3:0]),
		.in_expire (s_axis_tdata[35:4]),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	stq_engine #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	// Pack the result beat onto the output stream.
	assign m_axis_tdata = {3'b000, res.compare_at, res.compare_armed, res.expire_used,
		res.now_count, res.fired_slot};
	assign m_axis_tuser = res.fired;
	assign m_axis_tlast = res.last;

endmodule

`default_nettype wire

@@ rtl/core/stq_checker.sv @@
// Port-level checks for sorted_timer_queue, attached by the bind at the end.
// Depends only on the top level's ports.
`default_nettype none

module stq_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [103:0] m_axis_tdata,
	input wire logic         m_axis_tuser,
	input wire logic         m_axis_tlast
);

	// A stalled result beat keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	// A beat that reports no expiry is the only beat of its command.
	a_plain_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
		else $error("plain result beat without last");

	// A beat that reports no expiry names slot zero.
	a_plain_slot: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[3:0] == 4'd0)
		else $error("plain result beat with nonzero slot");

	// Expiry beats come from ticks, which store no expiry.
	a_fired_used: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[67:36] == 32'd0)
		else $error("expiry beat with nonzero stored expiry");

endmodule

bind sorted_timer_queue stq_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser),
	.m_axis_tlast (m_axis_tlast)
);

`default_nettype wire
